/* hw/rtl/dsfp_pkg.sv */
// Shared constants, request codes, event struct and divide-by-ten helper
// for the dust sensor frame parser. No dependencies.
package dsfp_pkg;

    localparam logic [1:0] REQ_BYTE     = 2'd0;
    localparam logic [1:0] REQ_LINE_ERR = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;

    localparam logic [7:0] HEAD_BYTE = 8'hA5;

    localparam int TENTHS_W = 16;
    localparam int WHOLE_W  = 13;
    localparam int CONC_W   = 14;

    // (x * 0xCCCD) >> 19 equals x / 10 for every x below 2^18
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam logic [4:0]  DIV10_SHIFT = 5'd19;

    typedef struct packed {
        logic                good;
        logic                bad;
        logic [TENTHS_W-1:0] tenths;
    } frame_evt_t;

    function automatic logic [WHOLE_W-1:0] div10_round(input logic [TENTHS_W-1:0] t);
        logic [TENTHS_W:0]   x;
        logic [2*TENTHS_W:0] p;
        begin
            x = {1'b0, t} + (TENTHS_W+1)'(5);
            p = (2*TENTHS_W+1)'(x) * (2*TENTHS_W+1)'(DIV10_MUL);
            div10_round = WHOLE_W'(p >> DIV10_SHIFT);
        end
    endfunction

endpackage

/* hw/rtl/dsfp_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on dsfp_pkg.
interface dsfp_req_if;
    import dsfp_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface dsfp_res_if;
    import dsfp_pkg::*;
    logic                valid;
    logic                ready;
    logic                frame_accepted;
    logic                checksum_bad;
    logic                read_ok;
    logic [TENTHS_W-1:0] dust_tenths;
    logic [WHOLE_W-1:0]  dust_whole;
    logic                new_data_pending;

    modport source (output valid, output frame_accepted, output checksum_bad,
                    output read_ok, output dust_tenths, output dust_whole,
                    output new_data_pending, input ready);
    modport sink   (input valid, input frame_accepted, input checksum_bad,
                    input read_ok, input dust_tenths, input dust_whole,
                    input new_data_pending, output ready);
endinterface

/* hw/rtl/dust_sensor_frame_parser.sv */
// Dust sensor frame parser top level: request handling, stored value,
// pending flag and result register. Depends on dsfp_pkg, dsfp_if, dsfp_frame_fsm.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | req_type, rx_byte                         | valid/ready
//   res     | out | frame_accepted, checksum_bad, read_ok,    | valid/ready
//           |     | dust_tenths, dust_whole, new_data_pending |
//
// One request per cycle while the result register is empty or draining; its result
// shows in the cycle after the transfer, from the single result register. The read
// path holds the divide-by-ten (reciprocal multiply) from the stored value.
// rst_n is asynchronous and active low; it clears the frame position,
// stored value, pending flag and result valid.
// A stalled result holds; a new request is taken in the cycle it drains.
module dust_sensor_frame_parser (
    input  logic       clk,
    input  logic       rst_n,
    dsfp_req_if.sink   req,
    dsfp_res_if.source res
);
    import dsfp_pkg::*;

    logic       accept;
    logic       is_read;
    frame_evt_t evt;

    logic [TENTHS_W-1:0] tenths_reg, tenths_next;
    logic                pending_reg, pending_next;
    logic                read_ok;

    logic                out_valid_reg;
    logic                fa_reg, cb_reg, ro_reg, pend_out_reg;
    logic [TENTHS_W-1:0] dt_reg;
    logic [WHOLE_W-1:0]  dw_reg;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign is_read   = (req.req_type == REQ_READ);
    assign read_ok   = is_read && pending_reg;

    dsfp_frame_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept && (req.req_type == REQ_BYTE)),
        .line_err   (accept && (req.req_type == REQ_LINE_ERR)),
        .rx_byte    (req.rx_byte),
        .evt        (evt)
    );

    always_comb
    begin
        tenths_next  = tenths_reg;
        pending_next = pending_reg;
        if (evt.good)
        begin
            tenths_next  = evt.tenths;
            pending_next = 1'b1;
        end
        else if (accept && read_ok)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tenths_reg    <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tenths_reg  <= tenths_next;
            pending_reg <= pending_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fa_reg       <= evt.good;
            cb_reg       <= evt.bad;
            ro_reg       <= read_ok;
            dt_reg       <= read_ok ? tenths_reg : '0;
            dw_reg       <= read_ok ? div10_round(tenths_reg) : '0;
            pend_out_reg <= pending_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.frame_accepted   = fa_reg;
    assign res.checksum_bad     = cb_reg;
    assign res.read_ok          = ro_reg;
    assign res.dust_tenths      = dt_reg;
    assign res.dust_whole       = dw_reg;
    assign res.new_data_pending = pend_out_reg;

endmodule

/* hw/rtl/dsfp_frame_fsm.sv */
// Frame position tracker and checksum check for the 4-byte sensor frame.
// Depends on dsfp_pkg.
module dsfp_frame_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic                 line_err,
    input  logic [7:0]           rx_byte,
    output dsfp_pkg::frame_evt_t evt
);
    import dsfp_pkg::*;

    localparam logic [1:0] IDX_HUNT  = 2'd0;
    localparam logic [1:0] IDX_DATA1 = 2'd1;
    localparam logic [1:0] IDX_DATA2 = 2'd2;
    localparam logic [1:0] IDX_CHECK = 2'd3;

    logic [1:0] idx_reg, idx_next;
    logic [7:0] data1_reg, data1_next;
    logic [7:0] data2_reg, data2_next;
    logic [6:0] sum7;
    logic [CONC_W-1:0] conc;
    logic [TENTHS_W-1:0] conc_ext;
    logic sum_match;

    // head byte is always 0xA5 once a frame is open
    assign sum7      = HEAD_BYTE[6:0] + data1_reg[6:0] + data2_reg[6:0];
    assign sum_match = (rx_byte == {1'b0, sum7});
    assign conc      = {data1_reg[6:0], data2_reg[6:0]};
    assign conc_ext  = TENTHS_W'(conc);

    always_comb
    begin
        idx_next   = idx_reg;
        data1_next = data1_reg;
        data2_next = data2_reg;
        evt.good   = 1'b0;
        evt.bad    = 1'b0;
        evt.tenths = (conc_ext << 3) + (conc_ext << 1);
        if (line_err)
        begin
            idx_next = IDX_HUNT;
        end
        else if (byte_valid)
        begin
            if (rx_byte == HEAD_BYTE)
            begin
                idx_next = IDX_DATA1;
            end
            else
            begin
                case (idx_reg)
                    IDX_HUNT:  idx_next = IDX_HUNT;
                    IDX_DATA1:
                    begin
                        data1_next = rx_byte;
                        idx_next   = IDX_DATA2;
                    end
                    IDX_DATA2:
                    begin
                        data2_next = rx_byte;
                        idx_next   = IDX_CHECK;
                    end
                    IDX_CHECK:
                    begin
                        evt.good = sum_match;
                        evt.bad  = !sum_match;
                        idx_next = IDX_HUNT;
                    end
                    default:   idx_next = IDX_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_HUNT;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data1_reg <= data1_next;
        data2_reg <= data2_next;
    end

endmodule

/* hw/rtl/dsfp_checker.sv */
// Port-level assertions for the dust sensor frame parser, bound to the top.
// Depends on dsfp_pkg and dust_sensor_frame_parser.
module dsfp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          frame_accepted,
    input logic                          checksum_bad,
    input logic                          read_ok,
    input logic [dsfp_pkg::TENTHS_W-1:0] dust_tenths,
    input logic [dsfp_pkg::WHOLE_W-1:0]  dust_whole,
    input logic                          new_data_pending
);
    import dsfp_pkg::*;

    // a stalled result holds its dust fields, read_ok and frame_accepted
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(dust_tenths)
            && $stable(dust_whole) && $stable(read_ok) && $stable(frame_accepted))
        else $error("result changed while stalled");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $countones({frame_accepted, checksum_bad, read_ok}) <= 1)
        else $error("more than one result kind flagged");

    a_dust_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !read_ok |-> dust_tenths == '0 && dust_whole == '0)
        else $error("dust fields nonzero without a read");

    a_good_sets: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_accepted |-> new_data_pending)
        else $error("good frame left pending flag clear");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && read_ok |-> !new_data_pending)
        else $error("read left pending flag set");

endmodule

bind dust_sensor_frame_parser dsfp_checker u_dsfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .frame_accepted   (res.frame_accepted),
    .checksum_bad     (res.checksum_bad),
    .read_ok          (res.read_ok),
    .dust_tenths      (res.dust_tenths),
    .dust_whole       (res.dust_whole),
    .new_data_pending (res.new_data_pending)
);

/* verif/dust_sensor_frame_parser_test.sv */
// Testbench for dust_sensor_frame_parser: directed and random event streams with
// random idling on both channels, checked against a cycle-free frame parser model.
// Depends on dsfp_pkg, dsfp_if and the dust_sensor_frame_parser RTL.
`timescale 1ns / 1ps

module dust_sensor_frame_parser_test;
    import dsfp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT = 34;

    typedef struct packed {
        logic                frame_accepted;
        logic                checksum_bad;
        logic                read_ok;
        logic [TENTHS_W-1:0] dust_tenths;
        logic [WHOLE_W-1:0]  dust_whole;
        logic                new_data_pending;
    } sensor_report_t;

    logic clk;
    logic rst_n;

    dsfp_req_if req_ch ();
    dsfp_res_if res_ch ();

    dust_sensor_frame_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // parser model state
    logic [1:0]          frame_pos;
    logic [7:0]          frame_buf [3];
    logic [TENTHS_W-1:0] stored_tenths;
    logic                data_pending;

    sensor_report_t expected_reports [$];
    int  mismatch_count;
    int  events_sent;
    bit  steady_mode;
    int  hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] frame_sum(input logic [7:0] d1, input logic [7:0] d2);
        logic [9:0] s;
        begin
            s = 10'(HEAD_BYTE) + 10'(d1) + 10'(d2);
            frame_sum = {1'b0, s[6:0]};
        end
    endfunction

    // Advances the model by one event and returns the report it should produce.
    function automatic sensor_report_t parse_event(input logic [1:0] kind,
                                                   input logic [7:0] b);
        sensor_report_t    r;
        logic [9:0]        s;
        logic [CONC_W-1:0] conc;
        logic [31:0]       wide;
        begin
            r = '0;
            if (kind == REQ_BYTE) begin
                if (b == HEAD_BYTE) begin
                    // head restarts from any position
                    frame_buf[0] = b;
                    frame_pos    = 2'd1;
                end
                else if (frame_pos == 2'd0) begin
                    // hunting, byte dropped
                end
                else if (frame_pos != 2'd3) begin
                    frame_buf[frame_pos] = b;
                    frame_pos            = frame_pos + 2'd1;
                end
                else begin
                    s = 10'(frame_buf[0]) + 10'(frame_buf[1]) + 10'(frame_buf[2]);
                    if (b == {1'b0, s[6:0]}) begin
                        conc          = {frame_buf[1][6:0], frame_buf[2][6:0]};
                        wide          = 32'(conc) * 32'd10;
                        stored_tenths = wide[TENTHS_W-1:0];
                        data_pending  = 1'b1;
                        r.frame_accepted = 1'b1;
                    end
                    else
                        r.checksum_bad = 1'b1;
                    frame_pos = 2'd0;
                end
            end
            else if (kind == REQ_LINE_ERR)
                frame_pos = 2'd0;
            else if (kind == REQ_READ) begin
                if (data_pending) begin
                    wide          = (32'(stored_tenths) + 32'd5) / 32'd10;
                    r.read_ok     = 1'b1;
                    r.dust_tenths = stored_tenths;
                    r.dust_whole  = wide[WHOLE_W-1:0];
                    data_pending  = 1'b0;
                end
            end
            r.new_data_pending = data_pending;
            parse_event = r;
        end
    endfunction

    // Offers one event, with a random gap first outside steady mode, and records its report on transfer.
    task automatic send_event(input logic [1:0] kind, input logic [7:0] b);
        begin
            while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid    <= 1'b1;
            req_ch.req_type <= kind;
            req_ch.rx_byte  <= b;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            expected_reports.push_back(parse_event(kind, b));
            events_sent++;
        end
    endtask

    task automatic send_frame(input logic [7:0] d1, input logic [7:0] d2, input bit corrupt);
        logic [7:0] cks;
        begin
            cks = frame_sum(d1, d2);
            if (corrupt) begin
                if ($urandom_range(1))
                    cks = cks | 8'h80;
                else
                    cks = cks ^ 8'($urandom_range(127, 1));
            end
            send_event(REQ_BYTE, HEAD_BYTE);
            send_event(REQ_BYTE, d1);
            send_event(REQ_BYTE, d2);
            send_event(REQ_BYTE, cks);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatch_count++;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : report_check
        sensor_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result transfer with no report expected");
                mismatch_count++;
            end
            else begin
                want = expected_reports.pop_front();
                check_field("frame_accepted", want.frame_accepted, res_ch.frame_accepted);
                check_field("checksum_bad", want.checksum_bad, res_ch.checksum_bad);
                check_field("read_ok", want.read_ok, res_ch.read_ok);
                check_field("dust_tenths", want.dust_tenths, res_ch.dust_tenths);
                check_field("dust_whole", want.dust_whole, res_ch.dust_whole);
                check_field("new_data_pending", want.new_data_pending,
                            res_ch.new_data_pending);
            end
        end
    end

    // result-side ready; a long hold is counted down here
    initial
    begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                res_ch.ready <= 1'b0;
            end
            else if (steady_mode)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic test_directed;
        begin
            send_event(REQ_READ, 8'h00);            // read with nothing pending
            send_event(REQ_BYTE, 8'h00);            // hunting
            send_event(REQ_BYTE, 8'hFF);
            send_event(REQ_UNUSED, 8'hFF);
            send_frame(8'h7F, 8'h7F, 1'b0);         // largest value, product wraps
            send_event(REQ_READ, 8'h00);
            send_event(REQ_BYTE, HEAD_BYTE);
            send_event(REQ_BYTE, HEAD_BYTE);        // head at position 1
            send_event(REQ_BYTE, 8'h12);
            send_event(REQ_BYTE, HEAD_BYTE);        // head at position 2
            send_event(REQ_BYTE, 8'h34);
            send_event(REQ_BYTE, 8'h56);
            send_event(REQ_BYTE, HEAD_BYTE);        // head in checksum slot
            send_event(REQ_BYTE, 8'h00);
            send_event(REQ_BYTE, 8'h00);
            send_event(REQ_BYTE, frame_sum(8'h00, 8'h00));
            send_frame(8'h80, 8'hFF, 1'b1);         // data bits 7 set, bad checksum
            send_event(REQ_BYTE, HEAD_BYTE);
            send_event(REQ_BYTE, 8'h01);
            send_event(REQ_LINE_ERR, 8'h00);        // drops partial frame
            send_event(REQ_BYTE, 8'h02);
            send_event(REQ_READ, 8'h00);
        end
    endtask

    // Mostly well-formed frames with random content, plus reads, noise and broken frames.
    task automatic test_random_traffic(input int target);
        int pick;
        int n;
        begin
            while (events_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_frame(8'($urandom), 8'($urandom), pick >= 58);
                    if ($urandom_range(1))
                        send_event(REQ_READ, 8'($urandom));
                end
                else if (pick < 78)
                    send_event(REQ_READ, 8'($urandom));
                else if (pick < 83)
                    send_event(REQ_BYTE, 8'($urandom));
                else if (pick < 90) begin
                    send_event(REQ_BYTE, HEAD_BYTE);
                    n = $urandom_range(2);
                    repeat (n)
                        send_event(REQ_BYTE, 8'($urandom));
                    send_event($urandom_range(1) ? REQ_LINE_ERR : REQ_BYTE, 8'($urandom));
                end
                else if (pick < 95)
                    send_event(REQ_LINE_ERR, 8'($urandom));
                else
                    send_event(REQ_UNUSED, 8'($urandom));
            end
        end
    endtask

    task automatic test_steady_stream;
        begin
            steady_mode = 1'b1;
            test_random_traffic(events_sent + 200);
            steady_mode = 1'b0;
        end
    endtask

    task automatic test_backpressure;
        begin
            hold_left = 300;
            test_random_traffic(events_sent + 40);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_BYTE;
        req_ch.rx_byte  = 8'h00;
        frame_pos       = 2'd0;
        frame_buf[0]    = 8'h00;
        frame_buf[1]    = 8'h00;
        frame_buf[2]    = 8'h00;
        stored_tenths   = '0;
        data_pending    = 1'b0;
        mismatch_count  = 0;
        events_sent     = 0;
        steady_mode     = 1'b0;
        hold_left       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(events_sent + 500);
        test_steady_stream();
        test_backpressure();
        test_random_traffic(events_sent + 500);

        req_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
